>>> rtl/core/dpcm_pkg.sv
package dpcm_pkg;

  localparam int LOG_TABLE_BITS = 6;
  localparam int TABLE_LEN      = (1 << LOG_TABLE_BITS) + 1;
  localparam int TIDX_W         = LOG_TABLE_BITS + 1;

  localparam int DATA_W     = 32;
  localparam int SCALE_W    = 31;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DATA_W;

  localparam int FRAC_Q   = 16;
  localparam int FB       = DATA_W - LOG_TABLE_BITS;
  localparam int TAB_W    = 30;
  localparam int POS_W    = 5;
  localparam int LN_W     = 35;
  localparam int LN_SHIFT = 14;
  localparam int DIFF_W   = DATA_W + 1;
  localparam int PROD_W   = 64;

  localparam logic [TAB_W-1:0]   LN2_Q30     = TAB_W'(744261118);
  localparam logic [DATA_W-1:0]  ONE_Q16     = DATA_W'(1) << FRAC_Q;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_Q;
  localparam logic [DATA_W-1:0]  POS_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  POS_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LIN     = 2'd0,
    MODE_LOG     = 2'd1,
    MODE_LOG1    = 2'd2,
    MODE_LIN_ALT = 2'd3
  } axis_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MODES = 3'd0,
    REG_FLIP        = 3'd1,
    REG_ABS_LO_X    = 3'd2,
    REG_ABS_LO_Y    = 3'd3,
    REG_DATA_LO_X   = 3'd4,
    REG_DATA_LO_Y   = 3'd5,
    REG_SCALE_X     = 3'd6,
    REG_SCALE_Y     = 3'd7
  } cfg_reg_e;

  typedef logic [TAB_W-1:0] ln_tab_t [TABLE_LEN];

  // ln(1 + i/2^LOG_TABLE_BITS) in Q30: log2 by repeated squaring, then times ln 2
  function automatic ln_tab_t build_ln_table();
    ln_tab_t     tab;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] e;
    for (int i = 0; i < TABLE_LEN; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      y = '0;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        y = 64'd1 << 30;
      end
      for (int k = 1; k <= 30; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          y = y | (64'd1 << (30 - k));
        end
      end
      e = (y * 64'(LN2_Q30) + (64'd1 << 29)) >> 30;
      tab[i] = e[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam ln_tab_t LN_TABLE = build_ln_table();

endpackage

>>> rtl/core/dpcm_if.sv
interface dpcm_req_if import dpcm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     axis;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, axis, value, input ready);
  modport sink   (input valid, axis, value, output ready);
endinterface

interface dpcm_rsp_if import dpcm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] position;
  logic                     saturated;

  modport source (output valid, position, saturated, input ready);
  modport sink   (input valid, position, saturated, output ready);
endinterface

>>> rtl/core/data_to_plot_coordinate_map.sv
// Maps a data value to an absolute plot coordinate, both signed Q16.16.
// Request channel req_i carries the axis (0 x, 1 y) and the value; response
// channel rsp_o carries the position and a flag set when it was clipped.
// A transaction completes on a rising edge with valid and ready both high.
// Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
// high (mode select, flip, plot edges, data edges, scales); write only while
// no transaction is in flight.
// Nine register stages: input decode, leading-one search, normalize,
// table read, interpolation multiply, log sum, difference, scale multiply,
// output. One request is taken every cycle while rsp_o does not stall.
// Each stage holds its item until the next stage is free, so a stall on
// rsp_o fills empty stages first and only then drops req_i.ready; nothing
// is lost or repeated.
// Reset clears every stage and loads the default configuration: linear
// mapping on both axes, no flip, zero edges, unit scale.
module data_to_plot_coordinate_map import dpcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dpcm_req_if.sink              req_i,
  dpcm_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int NSTG    = 9;
  localparam int NOPS    = 2;
  localparam int OP_D    = 0;
  localparam int OP_R    = 1;
  localparam int PM_W    = POS_W + 2;
  localparam int BASE_W  = PM_W + TAB_W + 1;
  localparam int LD_W    = LN_W + 1 - LN_SHIFT;
  localparam int MUL_W   = DIFF_W + SCALE_W + 1;
  localparam int SUM_W   = PROD_W - FRAC_Q + 1;

  typedef struct packed {
    logic [DATA_W-1:0]         arg;
    logic [POS_W-1:0]          p;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic [FB-1:0]             rem;
    logic [TAB_W-1:0]          lo;
    logic [TAB_W-1:0]          dl;
    logic [TAB_W-1:0]          ip;
    logic signed [LN_W-1:0]    base;
    logic signed [LN_W-1:0]    ln;
  } ln_op_t;

  typedef struct packed {
    logic                     use_y;
    logic                     ln_sel;
    logic                     zero_diff;
    logic                     ref_zero;
    logic signed [DIFF_W-1:0] lin_diff;
    ln_op_t [NOPS-1:0]        op;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [DATA_W-1:0]        position;
    logic                     saturated;
  } pipe_t;

  function automatic logic [POS_W-1:0] lead_one(logic [DATA_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int j = 0; j < DATA_W; j++) begin
      if (v[j]) p = POS_W'(j);
    end
    return p;
  endfunction

  logic [2*MODE_W-1:0]       scale_modes_q;
  logic                      flip_q;
  logic signed [DATA_W-1:0]  abs_lo_x_q, abs_lo_y_q;
  logic signed [DATA_W-1:0]  data_lo_x_q, data_lo_y_q;
  logic [SCALE_W-1:0]        scale_x_q, scale_y_q;

  logic [NSTG-1:0] v_q, vin, en;
  pipe_t           st_q [NSTG];
  pipe_t           st_d [NSTG];

  logic                     use_y, is_log, d_pos, dlo_pos;
  axis_mode_e               mode;
  logic signed [DATA_W-1:0] dlo;

  logic [2*DATA_W-1:0]      sh     [NOPS];
  logic [TIDX_W-1:0]        tix    [NOPS];
  logic [TAB_W-1:0]         hi     [NOPS];
  logic [TAB_W+FB-1:0]      ipf    [NOPS];
  logic signed [PM_W-1:0]   pm     [NOPS];
  logic signed [BASE_W-1:0] bf     [NOPS];
  logic signed [LN_W:0]     ldf;
  logic signed [LD_W-1:0]   ld;
  logic [SCALE_W-1:0]       sc;
  logic signed [MUL_W-1:0]  mul;
  logic signed [DATA_W-1:0] alo;
  logic signed [SUM_W-2:0]  psh;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-DATA_W:0]    sum_hi;
  logic                     sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_modes_q <= '0;
      flip_q        <= 1'b0;
      abs_lo_x_q    <= '0;
      abs_lo_y_q    <= '0;
      data_lo_x_q   <= '0;
      data_lo_y_q   <= '0;
      scale_x_q     <= SCALE_RESET;
      scale_y_q     <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SCALE_MODES: scale_modes_q <= cfg_wdata_i[2*MODE_W-1:0];
        REG_FLIP:        flip_q        <= cfg_wdata_i[0];
        REG_ABS_LO_X:    abs_lo_x_q    <= cfg_wdata_i[DATA_W-1:0];
        REG_ABS_LO_Y:    abs_lo_y_q    <= cfg_wdata_i[DATA_W-1:0];
        REG_DATA_LO_X:   data_lo_x_q   <= cfg_wdata_i[DATA_W-1:0];
        REG_DATA_LO_Y:   data_lo_y_q   <= cfg_wdata_i[DATA_W-1:0];
        REG_SCALE_X:     scale_x_q     <= cfg_wdata_i[SCALE_W-1:0];
        REG_SCALE_Y:     scale_y_q     <= cfg_wdata_i[SCALE_W-1:0];
        default:         ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || rsp_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign vin = {v_q[NSTG-2:0], req_i.valid};

  assign use_y   = req_i.axis ^ flip_q;
  assign mode    = axis_mode_e'(use_y ? scale_modes_q[2*MODE_W-1:MODE_W]
                                      : scale_modes_q[MODE_W-1:0]);
  assign dlo     = use_y ? data_lo_y_q : data_lo_x_q;
  assign is_log  = (mode == MODE_LOG) || (mode == MODE_LOG1);
  assign d_pos   = !req_i.value[DATA_W-1] && (|req_i.value);
  assign dlo_pos = !dlo[DATA_W-1] && (|dlo);

  always_comb begin
    // decode and log arguments
    st_d[0]           = '0;
    st_d[0].use_y     = use_y;
    st_d[0].ln_sel    = is_log && d_pos;
    st_d[0].zero_diff = is_log && !d_pos;
    st_d[0].ref_zero  = (mode == MODE_LOG) && !dlo_pos;
    st_d[0].lin_diff  = $signed({req_i.value[DATA_W-1], req_i.value})
                        - $signed({dlo[DATA_W-1], dlo});
    st_d[0].op[OP_D].arg = (mode == MODE_LOG1) ? req_i.value + ONE_Q16 : req_i.value;
    st_d[0].op[OP_R].arg = (mode == MODE_LOG1) ? (dlo_pos ? dlo : '0) + ONE_Q16 : dlo;

    st_d[1] = st_q[0];
    st_d[2] = st_q[1];
    st_d[3] = st_q[2];
    st_d[4] = st_q[3];
    st_d[5] = st_q[4];
    for (int o = 0; o < NOPS; o++) begin
      st_d[1].op[o].p = lead_one(st_q[0].op[o].arg);

      sh[o] = {{DATA_W{1'b0}}, st_q[1].op[o].arg}
              << (6'(DATA_W) - {1'b0, st_q[1].op[o].p});
      st_d[2].op[o].idx = sh[o][DATA_W-1 -: LOG_TABLE_BITS];
      st_d[2].op[o].rem = sh[o][FB-1:0];

      tix[o]           = {1'b0, st_q[2].op[o].idx};
      hi[o]            = LN_TABLE[tix[o] + TIDX_W'(1)];
      st_d[3].op[o].lo = LN_TABLE[tix[o]];
      st_d[3].op[o].dl = hi[o] - LN_TABLE[tix[o]];

      ipf[o]             = st_q[3].op[o].dl * st_q[3].op[o].rem;
      st_d[4].op[o].ip   = ipf[o][TAB_W+FB-1:FB];
      pm[o]              = $signed({2'b00, st_q[3].op[o].p}) - $signed(PM_W'(FRAC_Q));
      bf[o]              = pm[o] * $signed({1'b0, LN2_Q30});
      st_d[4].op[o].base = bf[o][LN_W-1:0];

      st_d[5].op[o].ln = st_q[4].op[o].base
                         + $signed({{(LN_W-TAB_W){1'b0}}, st_q[4].op[o].lo})
                         + $signed({{(LN_W-TAB_W){1'b0}}, st_q[4].op[o].ip});
    end
    if (st_q[4].ref_zero) begin
      st_d[5].op[OP_R].ln = '0;
    end

    // log difference rounded half up to Q16, the linear difference, or zero for a non-positive log input
    st_d[6] = st_q[5];
    ldf = $signed({st_q[5].op[OP_D].ln[LN_W-1], st_q[5].op[OP_D].ln})
          - $signed({st_q[5].op[OP_R].ln[LN_W-1], st_q[5].op[OP_R].ln})
          + $signed((LN_W+1)'(1) << (LN_SHIFT - 1));
    ld  = ldf[LN_W:LN_SHIFT];
    priority if (st_q[5].zero_diff) begin
      st_d[6].diff = '0;
    end else if (st_q[5].ln_sel) begin
      st_d[6].diff = $signed({{(DIFF_W-LD_W){ld[LD_W-1]}}, ld});
    end else begin
      st_d[6].diff = st_q[5].lin_diff;
    end

    st_d[7]      = st_q[6];
    sc           = st_q[6].use_y ? scale_y_q : scale_x_q;
    mul          = st_q[6].diff * $signed({1'b0, sc});
    st_d[7].prod = mul[PROD_W-1:0];

    // floor to Q16, add the edge, clip
    st_d[8] = st_q[7];
    alo     = st_q[7].use_y ? abs_lo_y_q : abs_lo_x_q;
    psh     = st_q[7].prod[PROD_W-1:FRAC_Q];
    sum     = $signed({psh[SUM_W-2], psh})
              + $signed({{(SUM_W-DATA_W){alo[DATA_W-1]}}, alo});
    sum_hi  = sum[SUM_W-1:DATA_W-1];
    sat     = !((&sum_hi) || !(|sum_hi));
    st_d[8].saturated = sat;
    st_d[8].position  = sat ? (sum[SUM_W-1] ? POS_MIN : POS_MAX) : sum[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  assign req_i.ready     = en[0];
  assign rsp_o.valid     = v_q[NSTG-1];
  assign rsp_o.position  = st_q[NSTG-1].position;
  assign rsp_o.saturated = st_q[NSTG-1].saturated;

endmodule

>>> dv/tb_data_to_plot_coordinate_map.sv
`timescale 1ns / 1ps

module tb_data_to_plot_coordinate_map;
  import dpcm_pkg::*;

  localparam logic  AXIS_X   = 1'b0;
  localparam logic  AXIS_Y   = 1'b1;
  localparam int    LN_LEN   = (1 << LOG_TABLE_BITS) + 1;
  localparam int    LN_FB    = 32 - LOG_TABLE_BITS;
  localparam longint LN2_FIX = 744261118;
  localparam longint POS_HI  = 64'sd2147483647;
  localparam longint POS_LO  = -64'sd2147483648;
  localparam int    PHASES   = 27;
  localparam int    PHASE_LEN = 50;

  typedef struct {
    logic signed [31:0] position;
    logic               saturated;
  } plot_point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dpcm_req_if req_if ();
  dpcm_rsp_if rsp_if ();

  data_to_plot_coordinate_map dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  longint unsigned    ln_tab [LN_LEN];
  logic [3:0]         axis_modes;
  logic               axis_flip;
  logic signed [31:0] abs_lo_x, abs_lo_y, data_lo_x, data_lo_y;
  logic [30:0]        scale_x, scale_y;

  plot_point_t expected_q[$];
  int          error_count;
  bit          src_idle_en;
  bit          snk_idle_en;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : ln_table_fill
    longint unsigned x, y;
    for (int i = 0; i < LN_LEN; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      y = 0;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        y = 64'd1 << 30;
      end
      for (int k = 1; k <= 30; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          y = y | (64'd1 << (30 - k));
        end
      end
      ln_tab[i] = (y * 64'(LN2_FIX) + (64'd1 << 29)) >> 30;
    end
  end

  function automatic longint ln_q30(logic [31:0] v);
    int unsigned     lead;
    longint unsigned frac, slot, rest, lo, hi;
    lead = 0;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) lead = b;
    end
    frac = ({32'd0, v} << (32 - lead)) & 64'hFFFF_FFFF;
    slot = frac >> LN_FB;
    rest = frac & ((64'd1 << LN_FB) - 1);
    lo   = ln_tab[slot];
    hi   = ln_tab[slot + 1];
    return (longint'(lead) - 16) * LN2_FIX + longint'(lo + (((hi - lo) * rest) >> LN_FB));
  endfunction

  function automatic plot_point_t predict_position(logic ax, logic signed [31:0] val);
    logic        use_y;
    axis_mode_e  mode;
    longint      d, dlo, alo, sc, ln_base, ln_val, diff, sum, shifted;
    plot_point_t r;
    use_y = ax ^ axis_flip;
    mode  = axis_mode_e'(use_y ? axis_modes[3:2] : axis_modes[1:0]);
    d     = longint'(val);
    alo   = use_y ? longint'(abs_lo_y) : longint'(abs_lo_x);
    dlo   = use_y ? longint'(data_lo_y) : longint'(data_lo_x);
    sc    = use_y ? longint'(scale_y) : longint'(scale_x);
    r.saturated = 1'b0;
    if (mode == MODE_LOG || mode == MODE_LOG1) begin
      if (d <= 0) begin
        r.position = alo[31:0];
        return r;
      end
      if (mode == MODE_LOG) begin
        ln_base = (dlo > 0) ? ln_q30(dlo[31:0]) : 64'sd0;
        ln_val  = ln_q30(d[31:0]);
      end else begin
        shifted = ((dlo > 0) ? dlo : 64'sd0) + 65536;
        ln_base = ln_q30(shifted[31:0]);
        shifted = d + 65536;
        ln_val  = ln_q30(shifted[31:0]);
      end
      diff = (ln_val - ln_base + 64'sd8192) >>> 14;
    end else begin
      diff = d - dlo;
    end
    sum = alo + ((diff * sc) >>> 16);
    if (sum > POS_HI) begin
      sum = POS_HI;
      r.saturated = 1'b1;
    end else if (sum < POS_LO) begin
      sum = POS_LO;
      r.saturated = 1'b1;
    end
    r.position = sum[31:0];
    return r;
  endfunction

  function automatic int draw_gap(bit en);
    return en ? int'($urandom_range(0, 13)) : 0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          default: return 32'h0000_0001;
        endcase
      end
      3: return {1'b0, 31'($urandom)} >> $urandom_range(0, 30);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_SCALE_MODES: axis_modes = data[3:0];
      REG_FLIP:        axis_flip  = data[0];
      REG_ABS_LO_X:    abs_lo_x   = data;
      REG_ABS_LO_Y:    abs_lo_y   = data;
      REG_DATA_LO_X:   data_lo_x  = data;
      REG_DATA_LO_Y:   data_lo_y  = data;
      REG_SCALE_X:     scale_x    = data[30:0];
      REG_SCALE_Y:     scale_y    = data[30:0];
      default: ;
    endcase
  endtask

  task automatic send_value(input logic ax, input logic [31:0] val);
    int gap;
    gap = draw_gap(src_idle_en);
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.axis  <= ax;
    req_if.value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(predict_position(ax, val));
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_value(AXIS_X, 32'h8000_0000);
    send_value(AXIS_Y, 32'h7FFF_FFFF);
    send_value(AXIS_X, 32'hFFFF_FFFF);
    send_value(AXIS_Y, 32'h0000_0000);
    wait_results();
  endtask

  task automatic test_linear_saturation();
    write_reg(REG_SCALE_MODES, {MODE_LIN, MODE_LIN_ALT});
    write_reg(REG_ABS_LO_X, 32'h7FFF_FFFF);
    write_reg(REG_DATA_LO_X, 32'h8000_0000);
    write_reg(REG_SCALE_X, 32'h7FFF_FFFF);
    write_reg(REG_ABS_LO_Y, 32'h8000_0000);
    write_reg(REG_DATA_LO_Y, 32'h7FFF_FFFF);
    write_reg(REG_SCALE_Y, 32'h7FFF_FFFF);
    send_value(AXIS_X, 32'h7FFF_FFFF);
    send_value(AXIS_X, 32'h8000_0000);
    send_value(AXIS_Y, 32'h8000_0000);
    send_value(AXIS_Y, 32'h7FFF_FFFF);
    wait_results();
    write_reg(REG_SCALE_Y, 32'h0000_0000);
    send_value(AXIS_Y, 32'h8000_0000);
    send_value(AXIS_X, 32'h0000_0000);
    wait_results();
  endtask

  task automatic test_log_modes();
    write_reg(REG_SCALE_MODES, {MODE_LOG1, MODE_LOG});
    write_reg(REG_ABS_LO_X, 32'h0000_0000);
    write_reg(REG_ABS_LO_Y, 32'h0010_0000);
    write_reg(REG_DATA_LO_X, 32'h0001_0000);
    write_reg(REG_DATA_LO_Y, 32'hFFFF_0000);
    write_reg(REG_SCALE_X, 32'h0001_0000);
    write_reg(REG_SCALE_Y, 32'h7FFF_FFFF);
    send_value(AXIS_X, 32'h0000_0000);
    send_value(AXIS_X, 32'h8000_0000);
    send_value(AXIS_X, 32'h0000_0001);
    send_value(AXIS_X, 32'h7FFF_FFFF);
    send_value(AXIS_X, 32'h0002_8000);
    send_value(AXIS_Y, 32'hFFFF_FFFF);
    send_value(AXIS_Y, 32'h0000_0001);
    send_value(AXIS_Y, 32'h7FFF_FFFF);
    wait_results();
    write_reg(REG_DATA_LO_X, 32'hFFFF_FFFB);
    write_reg(REG_DATA_LO_Y, 32'h0003_0000);
    send_value(AXIS_X, 32'h0001_0000);
    send_value(AXIS_Y, 32'h0001_0000);
    wait_results();
  endtask

  task automatic test_flip();
    write_reg(REG_SCALE_MODES, {MODE_LOG, MODE_LIN});
    write_reg(REG_FLIP, 32'h0000_0001);
    send_value(AXIS_X, 32'h0002_0000);
    send_value(AXIS_Y, 32'h0002_0000);
    send_value(AXIS_X, 32'hFFFE_0000);
    wait_results();
    write_reg(REG_FLIP, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      wait_results();
      write_reg(REG_SCALE_MODES, $urandom_range(0, 15));
      write_reg(REG_FLIP, $urandom_range(0, 1));
      write_reg(REG_ABS_LO_X, pick_word());
      write_reg(REG_ABS_LO_Y, pick_word());
      write_reg(REG_DATA_LO_X, pick_word());
      write_reg(REG_DATA_LO_Y, pick_word());
      write_reg(REG_SCALE_X, pick_scale());
      write_reg(REG_SCALE_Y, pick_scale());
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2 && (p == 0 || $urandom_range(0, 3) == 0)) wait_results();
        send_value(1'($urandom_range(0, 1)), pick_word());
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    wait_results();
  endtask

  initial begin : response_sink
    int gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(snk_idle_en);
      if (gap > 0) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    plot_point_t exp_pt;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: position %0d saturated %0b",
               rsp_if.position, rsp_if.saturated);
        error_count++;
      end else begin
        exp_pt = expected_q.pop_front();
        if (rsp_if.position !== exp_pt.position) begin
          $error("position: expected %0d, actual %0d", exp_pt.position, rsp_if.position);
          error_count++;
        end
        if (rsp_if.saturated !== exp_pt.saturated) begin
          $error("saturated: expected %0b, actual %0b", exp_pt.saturated, rsp_if.saturated);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_SCALE_MODES;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.axis  = AXIS_X;
    req_if.value = '0;
    error_count  = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    axis_modes   = 4'd0;
    axis_flip    = 1'b0;
    abs_lo_x     = '0;
    abs_lo_y     = '0;
    data_lo_x    = '0;
    data_lo_y    = '0;
    scale_x      = 31'h0001_0000;
    scale_y      = 31'h0001_0000;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_linear_saturation();
    test_log_modes();
    test_flip();
    test_random_traffic();

    wait_results();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dpcm_pkg.sv
rtl/core/dpcm_if.sv
rtl/core/data_to_plot_coordinate_map.sv
dv/tb_data_to_plot_coordinate_map.sv
